[rtl/core/elf_pkg.sv]
// elf_pkg: shared types and constants of the exponential led fader core
// word layouts for input, result, queued operation and configuration
// no dependencies
package elf_pkg;

	// fixed field widths
	localparam int CMD_W        = 3;
	localparam int TIME_W       = 32;
	localparam int VALUE_W      = 9;
	localparam int LEVEL_INT_W  = 8;
	localparam int FINE_W       = 24;
	localparam int GAIN_W       = 17;
	localparam int GAIN_FRAC    = 16;
	localparam int DELAY_W      = 16;
	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 17;

	// rescale divider: dividend is target times new max
	localparam int DIV_W        = LEVEL_INT_W + VALUE_W;
	localparam int DIV_CNT_W    = $clog2(DIV_W);

	// command codes on the input word
	localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ON         = 3'd1;
	localparam logic [CMD_W-1:0] CMD_OFF        = 3'd2;
	localparam logic [CMD_W-1:0] CMD_TOGGLE     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SET_TARGET = 3'd4;
	localparam logic [CMD_W-1:0] CMD_SET_MAX    = 3'd5;
	localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd6;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_K     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_STEP_DELAY = 2'd1;

	localparam logic [GAIN_W-1:0]  GAIN_K_RESET     = 17'd3277;
	localparam logic [DELAY_W-1:0] STEP_DELAY_RESET = 16'd20;

	typedef enum logic [3:0] {
		OP_TICK,
		OP_ON,
		OP_OFF,
		OP_TOGGLE,
		OP_SET_TARGET,
		OP_SET_MAX,
		OP_CLEAR,
		OP_NONE,
		OP_REJECT
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MUL,
		ST_STEP,
		ST_SETTLE,
		ST_DIV,
		ST_FINISH,
		ST_OUT
	} back_state_t;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [TIME_W-1:0]  now_ms;
		logic [VALUE_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic [LEVEL_INT_W-1:0] pwm_level;
		logic [FINE_W-1:0]      current_fine;
		logic [LEVEL_INT_W-1:0] target_out;
		logic                   lamp_on_out;
		logic                   changes_out;
		logic                   rejected;
	} result_t;

	typedef struct packed {
		op_t                op;
		logic [TIME_W-1:0]  now_ms;
		logic [VALUE_W-1:0] value;
	} op_word_t;

	typedef struct packed {
		logic [GAIN_W-1:0]  gain_k;
		logic [DELAY_W-1:0] step_delay_ms;
	} cfg_t;

endpackage

[rtl/core/elf_front.sv]
// elf_front: input stage, takes words from the push side and classifies them
// into operations for the back end; depends on elf_pkg
module elf_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  elf_pkg::item_t    item,
	output logic              op_valid,
	input  logic              op_ready,
	output elf_pkg::op_word_t op_word
);
	import elf_pkg::*;

	logic     valid_q;
	op_word_t word_q;
	op_word_t word_d;
	logic     accept;

	always_comb begin
		word_d.now_ms = item.now_ms;
		word_d.value  = item.value;
		case (item.command)
			CMD_TICK:       word_d.op = OP_TICK;
			CMD_ON:         word_d.op = OP_ON;
			CMD_OFF:        word_d.op = OP_OFF;
			CMD_TOGGLE:     word_d.op = OP_TOGGLE;
			// a value above 255 can never pass the max check
			CMD_SET_TARGET: word_d.op = item.value[VALUE_W-1] ? OP_REJECT : OP_SET_TARGET;
			CMD_SET_MAX:    word_d.op = item.value[VALUE_W-1] ? OP_REJECT : OP_SET_MAX;
			CMD_CLEAR:      word_d.op = OP_CLEAR;
			default:        word_d.op = OP_NONE;
		endcase
	end

	assign full     = valid_q && !op_ready;
	assign accept   = push && !full;
	assign op_valid = valid_q;
	assign op_word  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (op_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_q <= word_d;
		end
	end

endmodule

[rtl/core/elf_queue.sv]
// elf_queue: small operation queue between front and back end
// depth is two to the power AW; depends on elf_pkg
module elf_queue #(
	parameter int AW = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_valid,
	output logic              wr_ready,
	input  elf_pkg::op_word_t wr_word,
	output logic              rd_valid,
	input  logic              rd_pop,
	output elf_pkg::op_word_t rd_word
);
	import elf_pkg::*;

	localparam int DEPTH = 1 << AW;

	op_word_t      mem [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;
	logic          do_wr;
	logic          do_rd;

	assign wr_ready = count_q != (AW+1)'(DEPTH);
	assign rd_valid = count_q != '0;
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_pop && rd_valid;
	assign rd_word  = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_word;
		end
	end

endmodule

[rtl/core/elf_back.sv]
// elf_back: executes queued operations on the fader state, with the step
// multiplier, the settle timer, the rescale divider and the result register; depends on elf_pkg
module elf_back #(
	parameter int FRAC_BITS         = 16,
	parameter int MAX_LEVEL_DEFAULT = 255
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_valid,
	output logic              op_pop,
	input  elf_pkg::op_word_t op_word,
	input  elf_pkg::cfg_t     cfg,
	output logic              empty,
	input  logic              pop,
	output elf_pkg::result_t  result
);
	import elf_pkg::*;

	localparam int LW     = LEVEL_INT_W + FRAC_BITS;
	localparam int PW     = LW + GAIN_W;
	localparam int STEP_W = PW + 1 - GAIN_FRAC;
	localparam logic [LW-1:0]   LEVEL_MAX  = '1;
	localparam logic [LW+9:0]   MIN_DIST   = (LW+10)'(1) << FRAC_BITS;
	localparam logic [LW+9:0]   DIST_SCALE = (LW+10)'(1000);
	localparam logic [PW:0]     ROUND_HALF = (PW+1)'(1) << (GAIN_FRAC - 1);

	back_state_t state_q, state_d;

	// fader state
	logic [LW-1:0]          cur_q;
	logic [LEVEL_INT_W-1:0] prev_int_q;
	logic [LEVEL_INT_W-1:0] target_q;
	logic [LEVEL_INT_W-1:0] max_q;
	logic                   lamp_q;
	logic                   armed_q;
	logic [TIME_W-1:0]      since_q;
	logic [TIME_W-1:0]      last_q;
	logic                   changes_q;
	logic                   rej_q;
	logic                   out_valid_q;
	logic [DIV_CNT_W-1:0]   cnt_q;

	// working registers
	op_word_t               op_q;
	logic [LW-1:0]          mag_q;
	logic                   up_q;
	logic [PW-1:0]          prod_q;
	logic [DIV_W-1:0]       quo_q;
	logic [LEVEL_INT_W-1:0] rem_q;
	result_t                result_q;

	logic [LW-1:0]          tgt_fix;
	logic [LW-1:0]          mag;
	logic [LW+9:0]          mag_scaled;
	logic                   far;
	logic [TIME_W-1:0]      delay_ext;
	logic                   step_due;
	logic                   settle_due;
	logic [PW:0]            round_sum;
	logic [STEP_W-1:0]      step;
	logic [LW+2:0]          up_sum;
	logic [LW-1:0]          next_level;
	logic [LEVEL_INT_W-1:0] cur_int;
	logic [LW-1:0]          floor_lvl;
	logic [LW-1:0]          floor_up;
	logic [LW-1:0]          settle_level;
	logic [LEVEL_INT_W:0]   rem_try;
	logic                   rem_ge;
	logic [LW+FINE_W-1:0]   fine_ext;
	logic                   out_free;

	always_comb begin
		tgt_fix    = {target_q, {FRAC_BITS{1'b0}}};
		mag        = (tgt_fix > cur_q) ? tgt_fix - cur_q : cur_q - tgt_fix;
		mag_scaled = {10'b0, mag} * DIST_SCALE;
		far        = mag_scaled > MIN_DIST;
		delay_ext  = {{(TIME_W-DELAY_W){1'b0}}, cfg.step_delay_ms};
		step_due   = (op_q.now_ms - last_q) > delay_ext;
		settle_due = (op_q.now_ms - since_q) > delay_ext;

		// gain product rounded half up at the gain's lsb
		round_sum  = {1'b0, prod_q} + ROUND_HALF;
		step       = round_sum[PW:GAIN_FRAC];
		up_sum     = {3'b0, cur_q} + {1'b0, step};
		if (up_q) begin
			next_level = (up_sum[LW+2:LW] != 3'b0) ? LEVEL_MAX : up_sum[LW-1:0];
		end else begin
			next_level = (step > {2'b0, cur_q}) ? '0 : cur_q - step[LW-1:0];
		end

		cur_int   = cur_q[LW-1:FRAC_BITS];
		floor_lvl = {cur_int, {FRAC_BITS{1'b0}}};
		floor_up  = (cur_int == '1) ? LEVEL_MAX :
			{cur_int + 1'b1, {FRAC_BITS{1'b0}}};
		if (armed_q && settle_due) begin
			settle_level = (cur_q > tgt_fix) ? floor_lvl : floor_up;
		end else begin
			settle_level = cur_q;
		end

		rem_try  = {rem_q, quo_q[DIV_W-1]};
		rem_ge   = rem_try >= {1'b0, max_q};
		fine_ext = {{FINE_W{1'b0}}, cur_q};
		out_free = !out_valid_q || pop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		op_pop  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (op_valid) begin
					op_pop  = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (op_q.op)
					OP_TICK:    state_d = (far && step_due) ? ST_MUL : ST_OUT;
					OP_SET_MAX: state_d = (max_q == '0) ? ST_OUT : ST_DIV;
					default:    state_d = ST_OUT;
				endcase
			end
			ST_MUL:    state_d = ST_STEP;
			ST_STEP:   state_d = ST_SETTLE;
			ST_SETTLE: state_d = ST_OUT;
			ST_DIV:    state_d = (cnt_q == '0) ? ST_FINISH : ST_DIV;
			ST_FINISH: state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			prev_int_q  <= '0;
			target_q    <= '0;
			max_q       <= LEVEL_INT_W'(MAX_LEVEL_DEFAULT);
			lamp_q      <= 1'b0;
			armed_q     <= 1'b0;
			since_q     <= '0;
			last_q      <= '0;
			changes_q   <= 1'b0;
			rej_q       <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_EXEC: begin
					// a set max refusal after rescaling is decided in the finish step
					rej_q <= (op_q.op == OP_REJECT) ||
						((op_q.op == OP_SET_TARGET) && (op_q.value > {1'b0, max_q}));
					case (op_q.op)
						OP_TICK: begin
							if (far && step_due) begin
								last_q <= op_q.now_ms;
							end
						end
						OP_ON: begin
							changes_q <= 1'b1;
							lamp_q    <= 1'b1;
							target_q  <= max_q;
						end
						OP_OFF: begin
							changes_q <= 1'b1;
							lamp_q    <= 1'b0;
							target_q  <= '0;
						end
						OP_TOGGLE: begin
							changes_q <= 1'b1;
							lamp_q    <= !lamp_q;
							target_q  <= lamp_q ? '0 : max_q;
						end
						OP_SET_TARGET: begin
							if (op_q.value <= {1'b0, max_q}) begin
								target_q <= op_q.value[LEVEL_INT_W-1:0];
							end
						end
						OP_SET_MAX: begin
							// old max of zero drops the target to zero
							if (max_q == '0) begin
								max_q    <= op_q.value[LEVEL_INT_W-1:0];
								target_q <= '0;
							end
							cnt_q <= DIV_CNT_W'(DIV_W - 1);
						end
						OP_CLEAR:  changes_q <= 1'b0;
						default: ;
					endcase
				end
				ST_STEP: cur_q <= next_level;
				ST_SETTLE: begin
					cur_q      <= settle_level;
					prev_int_q <= settle_level[LW-1:FRAC_BITS];
					changes_q  <= 1'b1;
					if (armed_q) begin
						if (settle_due) begin
							armed_q <= 1'b0;
						end
					end else if (cur_int == prev_int_q) begin
						armed_q <= 1'b1;
						since_q <= op_q.now_ms;
					end
				end
				ST_DIV: cnt_q <= cnt_q - 1'b1;
				ST_FINISH: begin
					max_q <= op_q.value[LEVEL_INT_W-1:0];
					if (quo_q <= {{(DIV_W-VALUE_W){1'b0}}, op_q.value}) begin
						target_q <= quo_q[LEVEL_INT_W-1:0];
					end else begin
						rej_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop) begin
			op_q <= op_word;
		end
		case (state_q)
			ST_EXEC: begin
				mag_q <= mag;
				up_q  <= tgt_fix >= cur_q;
				quo_q <= DIV_W'({{VALUE_W{1'b0}}, target_q} * {{LEVEL_INT_W{1'b0}}, op_q.value});
				rem_q <= '0;
			end
			ST_MUL: prod_q <= {{GAIN_W{1'b0}}, mag_q} * {{LW{1'b0}}, cfg.gain_k};
			ST_DIV: begin
				// restoring divider, one quotient bit per cycle
				quo_q <= {quo_q[DIV_W-2:0], rem_ge};
				rem_q <= rem_ge ? LEVEL_INT_W'(rem_try - {1'b0, max_q}) :
					rem_try[LEVEL_INT_W-1:0];
			end
			ST_OUT: begin
				if (out_free) begin
					result_q.pwm_level    <= cur_int;
					result_q.current_fine <= fine_ext[FINE_W-1:0];
					result_q.target_out   <= target_q;
					result_q.lamp_on_out  <= lamp_q;
					result_q.changes_out  <= changes_q;
					result_q.rejected     <= rej_q;
				end
			end
			default: ;
		endcase
	end

	assign empty  = !out_valid_q;
	assign result = result_q;

endmodule

[rtl/core/exponential_led_fader_core.sv]
// exponential_led_fader_core: top level of the led fader, front stage, operation
// queue, back end and configuration registers; depends on elf_pkg and the elf modules
//
// Every input word yields exactly one result word, in order. Words are pushed
// into a front register and a queue of 2**QUEUE_AW operations, so the push side
// keeps accepting, until the queue fills, while the back end works or a result
// waits to be popped. The back end runs one operation at a time: on, off,
// toggle, set target, clear and ticks that take no step go from the execute
// state to the output state; a tick that takes a fade step runs the distance
// test, gain multiply, saturating add and settle update in turn; set max runs
// the restoring divider that rescales the target one quotient bit per cycle
// (not when the old max is zero).
// Configuration writes are always ready and are meant for an idle block.
module exponential_led_fader_core #(
	parameter int FRAC_BITS         = 16,
	parameter int MAX_LEVEL_DEFAULT = 255,
	parameter int QUEUE_AW          = 2
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  elf_pkg::item_t                   item,
	output logic                             empty,
	input  logic                             pop,
	output elf_pkg::result_t                 result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [elf_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [elf_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import elf_pkg::*;

	cfg_t     cfg_q;
	logic     f_valid;
	logic     f_ready;
	op_word_t f_word;
	logic     q_valid;
	logic     q_pop;
	op_word_t q_word;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_k        <= GAIN_K_RESET;
			cfg_q.step_delay_ms <= STEP_DELAY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GAIN_K:     cfg_q.gain_k        <= cfg_data[GAIN_W-1:0];
				REG_STEP_DELAY: cfg_q.step_delay_ms <= cfg_data[DELAY_W-1:0];
				default: ;
			endcase
		end
	end

	elf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.op_valid (f_valid),
		.op_ready (f_ready),
		.op_word  (f_word)
	);

	elf_queue #(
		.AW (QUEUE_AW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_word  (f_word),
		.rd_valid (q_valid),
		.rd_pop   (q_pop),
		.rd_word  (q_word)
	);

	elf_back #(
		.FRAC_BITS         (FRAC_BITS),
		.MAX_LEVEL_DEFAULT (MAX_LEVEL_DEFAULT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (q_valid),
		.op_pop   (q_pop),
		.op_word  (q_word),
		.cfg      (cfg_q),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule
